FILE: sv/pasc_pkg.sv
// ----------------------------------------------------------------------------
// pasc_pkg - shared types and constants of the primitive assembler
// Field widths, opcode and status codes, primitive types and the
// controller/datapath command and status bundles.
// ----------------------------------------------------------------------------
`default_nettype none

package pasc_pkg;

  localparam int CoordW = 16;
  localparam int DepthW = 32;
  localparam int AttrW  = 64;
  localparam int ApbAddrW = 5;
  localparam int ApbDataW = 32;

  // Opcode of an input item.
  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_KICK = 1'b1;

  // Register indexes on the configuration port.
  localparam logic [2:0] REG_PRIM_TYPE = 3'd0;
  localparam logic [2:0] REG_X_MIN     = 3'd1;
  localparam logic [2:0] REG_Y_MIN     = 3'd2;
  localparam logic [2:0] REG_X_MAX     = 3'd3;
  localparam logic [2:0] REG_Y_MAX     = 3'd4;

  typedef enum logic [2:0] {
    STS_EMIT    = 3'd0,
    STS_SKIP    = 3'd1,
    STS_REJECT  = 3'd2,
    STS_INVALID = 3'd3,
    STS_UNDER   = 3'd4
  } pasc_status_t;

  typedef enum logic [2:0] {
    PRIM_POINT      = 3'd0,
    PRIM_LINE_LIST  = 3'd1,
    PRIM_LINE_STRIP = 3'd2,
    PRIM_TRI_LIST   = 3'd3,
    PRIM_TRI_STRIP  = 3'd4,
    PRIM_FAN        = 3'd5,
    PRIM_SPRITE     = 3'd6,
    PRIM_INVALID    = 3'd7
  } pasc_prim_t;

  // How a kick removes vertices from the queue.
  typedef enum logic [2:0] {
    RM_NONE,
    RM_FRONT1,
    RM_FRONT2,
    RM_FRONT3,
    RM_SECOND
  } pasc_remove_t;

  typedef struct packed {
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
    logic [DepthW-1:0] z;
    logic [AttrW-1:0]  attr;
  } pasc_vtx_t;

  typedef struct packed {
    pasc_prim_t        prim_type;
    logic [CoordW-1:0] x_min;
    logic [CoordW-1:0] y_min;
    logic [CoordW-1:0] x_max;
    logic [CoordW-1:0] y_max;
  } pasc_cfg_t;

  // Controller to datapath.
  typedef struct packed {
    logic       push;
    logic       kick;
    logic [1:0] slot;
  } pasc_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic       in_kick;
    logic [1:0] last_slot;
  } pasc_sts_t;

  // Number of vertices a primitive of this type uses.
  function automatic logic [1:0] prim_need(pasc_prim_t t);
    logic [1:0] n;
    unique case (t)
      PRIM_POINT:      n = 2'd1;
      PRIM_LINE_LIST,
      PRIM_LINE_STRIP,
      PRIM_SPRITE:     n = 2'd2;
      PRIM_TRI_LIST,
      PRIM_TRI_STRIP,
      PRIM_FAN:        n = 2'd3;
      PRIM_INVALID:    n = 2'd0;
    endcase
    return n;
  endfunction

  function automatic pasc_remove_t prim_remove(pasc_prim_t t);
    pasc_remove_t r;
    unique case (t)
      PRIM_POINT,
      PRIM_LINE_STRIP,
      PRIM_TRI_STRIP:  r = RM_FRONT1;
      PRIM_LINE_LIST,
      PRIM_SPRITE:     r = RM_FRONT2;
      PRIM_TRI_LIST:   r = RM_FRONT3;
      PRIM_FAN:        r = RM_SECOND;
      PRIM_INVALID:    r = RM_NONE;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] remove_count(pasc_remove_t r);
    logic [1:0] n;
    unique case (r)
      RM_FRONT1, RM_SECOND: n = 2'd1;
      RM_FRONT2:            n = 2'd2;
      RM_FRONT3:            n = 2'd3;
      default:              n = 2'd0;
    endcase
    return n;
  endfunction

endpackage

`default_nettype wire

FILE: sv/pasc_if.sv
// ----------------------------------------------------------------------------
// pasc_if - item channels of the primitive assembler
// Input channel for push and kick items, output channel for result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface pasc_in_if;
  import pasc_pkg::*;

  logic              valid;
  logic              ready;
  logic              opcode;
  logic              skip_draw;
  logic [CoordW-1:0] pos_x;
  logic [CoordW-1:0] pos_y;
  logic [DepthW-1:0] pos_z;
  logic [AttrW-1:0]  attributes;

  modport source (output valid, opcode, skip_draw, pos_x, pos_y, pos_z, attributes,
                  input ready);
  modport sink   (input valid, opcode, skip_draw, pos_x, pos_y, pos_z, attributes,
                  output ready);
endinterface

interface pasc_out_if;
  import pasc_pkg::*;

  logic              valid;
  logic              ready;
  logic [2:0]        status;
  logic [1:0]        vertex_slot;
  logic [CoordW-1:0] out_x;
  logic [CoordW-1:0] out_y;
  logic [DepthW-1:0] out_z;
  logic [AttrW-1:0]  out_attributes;
  logic              last;

  modport source (output valid, status, vertex_slot, out_x, out_y, out_z, out_attributes,
                  last, input ready);
  modport sink   (input valid, status, vertex_slot, out_x, out_y, out_z, out_attributes,
                  last, output ready);
endinterface

`default_nettype wire

FILE: sv/pasc_ctrl.sv
// ----------------------------------------------------------------------------
// pasc_ctrl - controller of the primitive assembler
// Takes items in idle, then walks the result slots of a kick.
// ----------------------------------------------------------------------------
`default_nettype none

module pasc_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  pasc_pkg::pasc_sts_t sts,
  output pasc_pkg::pasc_cmd_t cmd
);
  import pasc_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EMIT = 2'b10
  } state_t;

  state_t     state, state_next;
  logic [1:0] slot, slot_next;

  assign in_ready  = (state == ST_IDLE);
  assign out_valid = (state == ST_EMIT);

  always_comb begin
    cmd.push = in_ready && in_valid && !sts.in_kick;
    cmd.kick = in_ready && in_valid && sts.in_kick;
    cmd.slot = slot;
  end

  always_comb begin
    state_next = state;
    slot_next  = slot;
    unique case (state)
      ST_IDLE: begin
        if (cmd.kick) begin
          state_next = ST_EMIT;
          slot_next  = 2'd0;
        end
      end
      ST_EMIT: begin
        if (out_ready) begin
          if (slot == sts.last_slot) begin
            state_next = ST_IDLE;
          end else begin
            slot_next = slot + 2'd1;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      slot  <= 2'd0;
    end else begin
      state <= state_next;
      slot  <= slot_next;
    end
  end

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input taken while results are pending");

  a_slot_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (slot <= sts.last_slot))
    else $error("result slot beyond last slot of the kick");

  a_kick_emits: assert property (@(posedge clk) disable iff (rst)
    cmd.kick |=> (out_valid && slot == 2'd0))
    else $error("kick did not start result output at slot zero");

endmodule

`default_nettype wire

FILE: sv/pasc_dp.sv
// ----------------------------------------------------------------------------
// pasc_dp - datapath of the primitive assembler
// Vertex queue, kick classification with scissor test, result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module pasc_dp #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                                clk,
  input  logic                                rst,
  input  pasc_pkg::pasc_cmd_t                 cmd,
  output pasc_pkg::pasc_sts_t                 sts,
  input  pasc_pkg::pasc_cfg_t                 cfg,
  input  logic                                opcode,
  input  logic                                skip_draw,
  input  logic [pasc_pkg::CoordW-1:0]         pos_x,
  input  logic [pasc_pkg::CoordW-1:0]         pos_y,
  input  logic [pasc_pkg::DepthW-1:0]         pos_z,
  input  logic [pasc_pkg::AttrW-1:0]          attributes,
  output logic [2:0]                          status,
  output logic [1:0]                          vertex_slot,
  output logic [pasc_pkg::CoordW-1:0]         out_x,
  output logic [pasc_pkg::CoordW-1:0]         out_y,
  output logic [pasc_pkg::DepthW-1:0]         out_z,
  output logic [pasc_pkg::AttrW-1:0]          out_attributes,
  output logic                                last
);
  import pasc_pkg::*;

  localparam int FillW = $clog2(QUEUE_DEPTH + 1);
  localparam int IdxW  = $clog2(QUEUE_DEPTH);
  localparam logic [FillW-1:0] FillFull = FillW'(QUEUE_DEPTH);

  pasc_vtx_t        queue [QUEUE_DEPTH];
  logic [FillW-1:0] fill;
  logic             full;

  pasc_vtx_t        vcap [3];
  pasc_status_t     res_status;
  logic [1:0]       res_last_slot;

  logic [1:0]       need;
  pasc_remove_t     rm;
  logic             enough;
  logic             reject;
  logic             do_remove;
  logic             do_clear;
  pasc_status_t     kick_status;
  logic [1:0]       kick_last;
  pasc_vtx_t        in_vtx;
  pasc_vtx_t        sel_vtx;

  assign full   = (fill == FillFull);
  assign need   = prim_need(cfg.prim_type);
  assign rm     = prim_remove(cfg.prim_type);
  assign enough = (fill >= FillW'(need));

  always_comb begin
    in_vtx.x    = pos_x;
    in_vtx.y    = pos_y;
    in_vtx.z    = pos_z;
    in_vtx.attr = attributes;
  end

  // A primitive is dropped when all of its vertices are beyond one edge.
  always_comb begin
    logic lx, hx, ly, hy;
    lx = 1'b1;
    hx = 1'b1;
    ly = 1'b1;
    hy = 1'b1;
    for (int i = 0; i < 3; i++) begin
      if (2'(i) < need) begin
        lx = lx && (queue[i].x < cfg.x_min);
        hx = hx && (queue[i].x > cfg.x_max);
        ly = ly && (queue[i].y < cfg.y_min);
        hy = hy && (queue[i].y > cfg.y_max);
      end
    end
    reject = lx || hx || ly || hy;
  end

  always_comb begin
    kick_status = STS_EMIT;
    kick_last   = need - 2'd1;
    do_remove   = 1'b0;
    do_clear    = 1'b0;
    if (cfg.prim_type == PRIM_INVALID) begin
      kick_status = STS_INVALID;
      kick_last   = 2'd0;
      do_clear    = 1'b1;
    end else if (!enough) begin
      kick_status = STS_UNDER;
      kick_last   = 2'd0;
    end else begin
      do_remove = 1'b1;
      if (skip_draw) begin
        kick_status = STS_SKIP;
        kick_last   = 2'd0;
      end else if (reject) begin
        kick_status = STS_REJECT;
        kick_last   = 2'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill          <= '0;
      res_status    <= STS_INVALID;
      res_last_slot <= 2'd0;
    end else begin
      if (cmd.push && !full) begin
        fill <= fill + FillW'(1);
      end else if (cmd.kick) begin
        if (do_clear) begin
          fill <= '0;
        end else if (do_remove) begin
          fill <= fill - FillW'(remove_count(rm));
        end
      end
      if (cmd.kick) begin
        res_status    <= kick_status;
        res_last_slot <= kick_last;
      end
    end
  end

  // Queue entries and captured vertices carry payload only.
  always_ff @(posedge clk) begin
    if (cmd.push && !full) begin
      queue[fill[IdxW-1:0]] <= in_vtx;
    end else if (cmd.kick && do_remove) begin
      unique case (rm)
        RM_FRONT1: begin
          for (int k = 0; k < QUEUE_DEPTH - 1; k++) queue[k] <= queue[k+1];
        end
        RM_FRONT2: begin
          for (int k = 0; k < QUEUE_DEPTH - 2; k++) queue[k] <= queue[k+2];
        end
        RM_FRONT3: begin
          for (int k = 0; k < QUEUE_DEPTH - 3; k++) queue[k] <= queue[k+3];
        end
        RM_SECOND: begin
          for (int k = 1; k < QUEUE_DEPTH - 1; k++) queue[k] <= queue[k+1];
        end
        default: ;
      endcase
    end
    if (cmd.kick) begin
      for (int i = 0; i < 3; i++) vcap[i] <= queue[i];
    end
  end

  always_comb begin
    unique case (cmd.slot)
      2'd1:    sel_vtx = vcap[1];
      2'd2:    sel_vtx = vcap[2];
      default: sel_vtx = vcap[0];
    endcase
  end

  always_comb begin
    status = res_status;
    last   = (cmd.slot == res_last_slot);
    if (res_status == STS_EMIT) begin
      vertex_slot    = cmd.slot;
      out_x          = sel_vtx.x;
      out_y          = sel_vtx.y;
      out_z          = sel_vtx.z;
      out_attributes = sel_vtx.attr;
    end else begin
      vertex_slot    = 2'd0;
      out_x          = '0;
      out_y          = '0;
      out_z          = '0;
      out_attributes = '0;
    end
  end

  always_comb begin
    sts.in_kick   = (opcode == OP_KICK);
    sts.last_slot = res_last_slot;
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FillFull)
    else $error("queue fill beyond depth");

  a_status_single: assert property (@(posedge clk) disable iff (rst)
    (res_status != STS_EMIT) |-> (res_last_slot == 2'd0))
    else $error("status-only kick with more than one result");

  a_full_drop: assert property (@(posedge clk) disable iff (rst)
    (cmd.push && full) |=> $stable(fill))
    else $error("push to a full queue changed the fill count");

  a_invalid_clears: assert property (@(posedge clk) disable iff (rst)
    (cmd.kick && cfg.prim_type == PRIM_INVALID) |=> (fill == '0))
    else $error("invalid-type kick did not clear the queue");

endmodule

`default_nettype wire

FILE: sv/primitive_assembly_scissor_cull_core.sv
// ----------------------------------------------------------------------------
// primitive_assembly_scissor_cull_core - primitive assembler with scissor cull
// Top level: configuration registers, controller and datapath.
// ----------------------------------------------------------------------------
// Push items add a vertex to a queue of QUEUE_DEPTH entries; a push to a full
// queue is dropped and gives no result. A kick item assembles a primitive of
// the configured type from the oldest vertices, removes the vertices that the
// type consumes, and either emits the primitive as one result item per vertex
// (the last one marked) or gives a single status item for a skipped, scissor
// rejected, invalid-type or underflowing kick. The block can take a push
// every cycle while it is idle. A kick is accepted, then its result items
// follow one by one while the output is ready; the block holds one kick's
// results in a single set of result registers and takes no new item until
// the last of them is delivered. Configuration registers sit at byte
// addresses 0, 4, 8, 12 and 16; the user must see that they are written
// only while the block is idle, as the block itself does not enforce this.
`default_nettype none

module primitive_assembly_scissor_cull_core #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                             clk,
  input  logic                             rst,
  pasc_in_if.sink                          vtx_in,
  pasc_out_if.source                       prim_out,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [pasc_pkg::ApbAddrW-1:0]    paddr,
  input  logic [pasc_pkg::ApbDataW-1:0]    pwdata,
  output logic [pasc_pkg::ApbDataW-1:0]    prdata,
  output logic                             pready
);
  import pasc_pkg::*;

  pasc_cfg_t  cfg;
  pasc_cmd_t  cmd;
  pasc_sts_t  sts;
  logic       cfg_write;
  logic [2:0] reg_index;

  // The register file never stalls the bus.
  assign pready    = 1'b1;
  assign reg_index = paddr[4:2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.prim_type <= PRIM_POINT;
      cfg.x_min     <= '0;
      cfg.y_min     <= '0;
      cfg.x_max     <= '1;
      cfg.y_max     <= '1;
    end else if (cfg_write) begin
      unique case (reg_index)
        REG_PRIM_TYPE: cfg.prim_type <= pasc_prim_t'(pwdata[2:0]);
        REG_X_MIN:     cfg.x_min     <= pwdata[CoordW-1:0];
        REG_Y_MIN:     cfg.y_min     <= pwdata[CoordW-1:0];
        REG_X_MAX:     cfg.x_max     <= pwdata[CoordW-1:0];
        REG_Y_MAX:     cfg.y_max     <= pwdata[CoordW-1:0];
        default: ;
      endcase
    end
  end

  // Reads return the register value, zero for addresses past the list.
  always_comb begin
    unique case (reg_index)
      REG_PRIM_TYPE: prdata = ApbDataW'(cfg.prim_type);
      REG_X_MIN:     prdata = ApbDataW'(cfg.x_min);
      REG_Y_MIN:     prdata = ApbDataW'(cfg.y_min);
      REG_X_MAX:     prdata = ApbDataW'(cfg.x_max);
      REG_Y_MAX:     prdata = ApbDataW'(cfg.y_max);
      default:       prdata = '0;
    endcase
  end

  // The controller decides when items are taken and which result slot is
  // shown; the datapath holds the queue and classifies each kick.
  pasc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (vtx_in.valid),
    .in_ready  (vtx_in.ready),
    .out_valid (prim_out.valid),
    .out_ready (prim_out.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  pasc_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .cfg            (cfg),
    .opcode         (vtx_in.opcode),
    .skip_draw      (vtx_in.skip_draw),
    .pos_x          (vtx_in.pos_x),
    .pos_y          (vtx_in.pos_y),
    .pos_z          (vtx_in.pos_z),
    .attributes     (vtx_in.attributes),
    .status         (prim_out.status),
    .vertex_slot    (prim_out.vertex_slot),
    .out_x          (prim_out.out_x),
    .out_y          (prim_out.out_y),
    .out_z          (prim_out.out_z),
    .out_attributes (prim_out.out_attributes),
    .last           (prim_out.last)
  );

endmodule

`default_nettype wire

FILE: bench/primitive_assembly_scissor_cull_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// primitive_assembly_scissor_cull_core_test - primitive assembler testbench
// A short directed table, then random vertex streams under a series of
// primitive types and scissor windows. Every result item is compared field
// by field with an in-bench model of the vertex queue, primitive assembly
// and scissor trivial reject. Both handshake sides idle at random.
// ----------------------------------------------------------------------------

module primitive_assembly_scissor_cull_core_test;
  import pasc_pkg::*;

  localparam int QDepth     = 4;
  localparam int HalfPeriod = 10;
  localparam int PhaseItems = 24;
  localparam int RandItems  = 250;
  localparam int HoldCycles = 300;

  // One input item as the bench sees it.
  typedef struct {
    logic              opcode;
    logic              skip_draw;
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
    logic [DepthW-1:0] z;
    logic [AttrW-1:0]  attr;
  } vtx_item_t;

  // One result item.
  typedef struct packed {
    pasc_status_t      status;
    logic [1:0]        slot;
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
    logic [DepthW-1:0] z;
    logic [AttrW-1:0]  attr;
    logic              last;
  } prim_result_t;

  // Status typed into the directed table for a row, when it has one.
  typedef struct {
    bit           typed;
    pasc_status_t want;
  } listed_status_t;

  typedef enum logic {ROW_ITEM, ROW_REG} row_kind_t;

  typedef struct {
    row_kind_t    kind;
    logic [2:0]   reg_index;
    logic [15:0]  reg_value;
    vtx_item_t    item;
    bit           typed;
    pasc_status_t want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst;
  logic psel, penable, pwrite;
  logic [ApbAddrW-1:0] paddr;
  logic [ApbDataW-1:0] pwdata;
  logic [ApbDataW-1:0] prdata;
  logic pready;

  pasc_in_if  vtx_in ();
  pasc_out_if prim_out ();

  primitive_assembly_scissor_cull_core #(
    .QUEUE_DEPTH(QDepth)
  ) i_dut (
    .clk     (clk),
    .rst     (rst),
    .vtx_in  (vtx_in),
    .prim_out(prim_out),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #(HalfPeriod) clk = ~clk;

  // Bench copy of the block's state: the vertex queue, its fill count and
  // the register settings as last written.
  pasc_vtx_t   vq[QDepth];
  int unsigned vq_fill;
  pasc_prim_t  cfg_type;
  logic [15:0] cfg_x_min, cfg_y_min, cfg_x_max, cfg_y_max;

  // Results still owed by the block, oldest first, and the typed statuses
  // of the items handed to the input, in the order they were handed over.
  prim_result_t   awaited_results[$];
  listed_status_t listed_status[$];

  int unsigned fails;
  bit          steady;    // both sides stop idling while set
  int unsigned hold_off;  // asks the receiver for a long hold-off

  // Number of vertices one primitive of the given type uses.
  function automatic int unsigned vertices_per_primitive(pasc_prim_t t);
    case (t)
      PRIM_POINT:                                   return 1;
      PRIM_LINE_LIST, PRIM_LINE_STRIP, PRIM_SPRITE: return 2;
      PRIM_INVALID:                                 return 0;
      default:                                      return 3;
    endcase
  endfunction

  // Removes entry i from the queue and closes the gap behind it.
  function automatic pasc_vtx_t take_vertex(int unsigned i);
    pasc_vtx_t v;
    v = vq[i];
    for (int unsigned k = i; k + 1 < vq_fill; k++) vq[k] = vq[k + 1];
    vq_fill--;
    return v;
  endfunction

  // Works out the result items that one accepted input item causes and
  // updates the bench copy of the queue on the way.
  function automatic void assemble_primitive(input vtx_item_t it,
                                             output prim_result_t res[$]);
    pasc_vtx_t    v[3];
    int unsigned  need;
    bit           lo_x, hi_x, lo_y, hi_y, outside, a, b, c, d;
    prim_result_t r;
    res = {};
    if (it.opcode == OP_PUSH) begin
      // A push to a full queue is dropped silently.
      if (vq_fill < QDepth) begin
        vq[vq_fill] = '{x: it.x, y: it.y, z: it.z, attr: it.attr};
        vq_fill++;
      end
      return;
    end
    r = '0;
    r.last = 1'b1;
    if (cfg_type == PRIM_INVALID) begin
      vq_fill = 0;
      r.status = STS_INVALID;
      res.push_back(r);
      return;
    end
    need = vertices_per_primitive(cfg_type);
    if (vq_fill < need) begin
      r.status = STS_UNDER;
      res.push_back(r);
      return;
    end
    case (cfg_type)
      PRIM_POINT: v[0] = take_vertex(0);
      PRIM_LINE_LIST, PRIM_SPRITE: begin
        v[0] = take_vertex(0);
        v[1] = take_vertex(0);
      end
      PRIM_LINE_STRIP: begin
        v[0] = take_vertex(0);
        v[1] = vq[0];
      end
      PRIM_TRI_LIST: begin
        v[0] = take_vertex(0);
        v[1] = take_vertex(0);
        v[2] = take_vertex(0);
      end
      PRIM_TRI_STRIP: begin
        v[0] = take_vertex(0);
        v[1] = vq[0];
        v[2] = vq[1];
      end
      default: begin
        // Fan: the first vertex stays as the hub.
        v[0] = vq[0];
        v[1] = take_vertex(1);
        v[2] = vq[1];
      end
    endcase
    if (it.skip_draw) begin
      r.status = STS_SKIP;
      res.push_back(r);
      return;
    end
    lo_x = 1'b1;
    hi_x = 1'b1;
    lo_y = 1'b1;
    hi_y = 1'b1;
    outside = 1'b0;
    for (int i = 0; i < need; i++) begin
      a = v[i].x < cfg_x_min;
      b = v[i].x > cfg_x_max;
      c = v[i].y < cfg_y_min;
      d = v[i].y > cfg_y_max;
      lo_x &= a;
      hi_x &= b;
      lo_y &= c;
      hi_y &= d;
      outside |= a | b | c | d;
    end
    if ((need == 1 && outside) || lo_x || hi_x || lo_y || hi_y) begin
      r.status = STS_REJECT;
      res.push_back(r);
      return;
    end
    for (int i = 0; i < need; i++) begin
      r.status = STS_EMIT;
      r.slot   = 2'(i);
      r.x      = v[i].x;
      r.y      = v[i].y;
      r.z      = v[i].z;
      r.attr   = v[i].attr;
      r.last   = (i == need - 1);
      res.push_back(r);
    end
  endfunction

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fails++;
    end
  endfunction

  // Everything is sampled at the rising edge, before the block's own
  // updates of that edge land, so both sides see the values of the cycle
  // that just ended. A new item is predicted before any result is checked.
  always @(posedge clk) begin : track_items
    prim_result_t   fresh[$];
    prim_result_t   want;
    listed_status_t tag;
    if (!rst) begin
      if (vtx_in.valid && vtx_in.ready) begin
        assemble_primitive('{vtx_in.opcode, vtx_in.skip_draw, vtx_in.pos_x,
                             vtx_in.pos_y, vtx_in.pos_z, vtx_in.attributes}, fresh);
        tag = listed_status.pop_front();
        if (tag.typed) begin
          // Rows of the directed table with a status typed in are held to
          // that status-only result.
          want = '0;
          want.status = tag.want;
          want.last = 1'b1;
          awaited_results.push_back(want);
        end else begin
          foreach (fresh[k]) awaited_results.push_back(fresh[k]);
        end
      end
      if (prim_out.valid && prim_out.ready) begin
        if (awaited_results.size() == 0) begin
          $error("result item with none expected: status %0d x %0h y %0h",
                 prim_out.status, prim_out.out_x, prim_out.out_y);
          fails++;
        end else begin
          want = awaited_results.pop_front();
          check_field("status", 64'(want.status), 64'(prim_out.status));
          check_field("vertex_slot", 64'(want.slot), 64'(prim_out.vertex_slot));
          check_field("out_x", 64'(want.x), 64'(prim_out.out_x));
          check_field("out_y", 64'(want.y), 64'(prim_out.out_y));
          check_field("out_z", 64'(want.z), 64'(prim_out.out_z));
          check_field("out_attributes", want.attr, prim_out.out_attributes);
          check_field("last", 64'(want.last), 64'(prim_out.last));
        end
      end
    end
  end

  // Output side. Ready drops in about a fifth of the cycles, never while
  // the steady flag is up, and stays low for the whole of a requested
  // hold-off, which is counted here.
  initial begin : receiver
    prim_out.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off != 0) begin
        prim_out.ready <= 1'b0;
        repeat (hold_off) @(posedge clk);
        hold_off = 0;
        prim_out.ready <= 1'b1;
      end else begin
        prim_out.ready <= steady || ($urandom_range(0, 99) >= 22);
      end
    end
  end

  // Offers one item, with a random gap in front of it, and returns at the
  // edge that accepts it. Valid is left high for the next call.
  task automatic send_item(input vtx_item_t it, input bit typed, input pasc_status_t want);
    listed_status.push_back('{typed, want});
    while (!steady && $urandom_range(0, 99) < 22) begin
      vtx_in.valid <= 1'b0;
      @(posedge clk);
    end
    vtx_in.valid      <= 1'b1;
    vtx_in.opcode     <= it.opcode;
    vtx_in.skip_draw  <= it.skip_draw;
    vtx_in.pos_x      <= it.x;
    vtx_in.pos_y      <= it.y;
    vtx_in.pos_z      <= it.z;
    vtx_in.attributes <= it.attr;
    @(posedge clk);
    while (!vtx_in.ready) @(posedge clk);
  endtask

  // Stops offering items and waits until every owed result is out and a
  // trailing push has settled too.
  task automatic drain();
    vtx_in.valid <= 1'b0;
    @(posedge clk);
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // One register write: setup cycle, access cycle, then back to idle. The
  // bits above the register's width carry noise that the block must drop.
  task automatic write_register(input logic [2:0] index, input logic [15:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ApbAddrW'({index, 2'b00});
    pwdata  <= {16'($urandom), value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (index)
      REG_PRIM_TYPE: cfg_type  = pasc_prim_t'(value[2:0]);
      REG_X_MIN:     cfg_x_min = value;
      REG_Y_MIN:     cfg_y_min = value;
      REG_X_MAX:     cfg_x_max = value;
      REG_Y_MAX:     cfg_y_max = value;
      default: ;
    endcase
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Coordinates lean toward both ends of the range.
  function automatic logic [15:0] random_coord();
    case ($urandom_range(0, 7))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic vtx_item_t random_vertex();
    vtx_item_t it;
    it.opcode    = OP_PUSH;
    it.skip_draw = 1'($urandom_range(0, 1));
    it.x         = random_coord();
    it.y         = random_coord();
    it.z         = $urandom;
    it.attr      = {$urandom, $urandom};
    return it;
  endfunction

  function automatic stim_row_t push_row(input logic [15:0] x, y, input logic [31:0] z,
                                         input logic [63:0] attr, input bit skip);
    stim_row_t r;
    r.kind      = ROW_ITEM;
    r.reg_index = '0;
    r.reg_value = '0;
    r.item      = '{OP_PUSH, skip, x, y, z, attr};
    r.typed     = 1'b0;
    r.want      = STS_EMIT;
    return r;
  endfunction

  function automatic stim_row_t kick_row(input bit skip, input bit typed,
                                         input pasc_status_t want);
    stim_row_t r;
    r.kind      = ROW_ITEM;
    r.reg_index = '0;
    r.reg_value = '0;
    r.item      = '{OP_KICK, skip, 16'h0000, 16'h0000, 32'h0, 64'h0};
    r.typed     = typed;
    r.want      = want;
    return r;
  endfunction

  function automatic stim_row_t reg_row(input logic [2:0] index, input logic [15:0] value);
    stim_row_t r;
    r.kind      = ROW_REG;
    r.reg_index = index;
    r.reg_value = value;
    r.item      = '{OP_PUSH, 1'b0, 16'h0000, 16'h0000, 32'h0, 64'h0};
    r.typed     = 1'b0;
    r.want      = STS_EMIT;
    return r;
  endfunction

  initial begin : stimulus
    stim_row_t    rows[$];
    vtx_item_t    it;
    pasc_prim_t   new_type;
    logic [15:0]  new_x_min, new_y_min, new_x_max, new_y_max;
    int unsigned  sent, phase, phase_items, need, burst, scissor_mode;

    fails    = 0;
    steady   = 1'b0;
    hold_off = 0;
    vq_fill  = 0;
    cfg_type  = PRIM_POINT;
    cfg_x_min = 16'h0000;
    cfg_y_min = 16'h0000;
    cfg_x_max = 16'hFFFF;
    cfg_y_max = 16'hFFFF;
    foreach (vq[k]) vq[k] = '0;

    rst               <= 1'b1;
    psel              <= 1'b0;
    penable           <= 1'b0;
    pwrite            <= 1'b0;
    paddr             <= '0;
    pwdata            <= '0;
    vtx_in.valid      <= 1'b0;
    vtx_in.opcode     <= OP_PUSH;
    vtx_in.skip_draw  <= 1'b0;
    vtx_in.pos_x      <= '0;
    vtx_in.pos_y      <= '0;
    vtx_in.pos_z      <= '0;
    vtx_in.attributes <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table. After reset the type is point and the scissor window
    // spans the whole screen.
    // A kick on the empty queue underflows.
    rows.push_back(kick_row(1'b0, 1'b1, STS_UNDER));
    // All-zero and all-ones vertices; skip_draw on a push has no effect.
    rows.push_back(push_row(16'h0000, 16'h0000, 32'h0000_0000, 64'h0, 1'b0));
    rows.push_back(kick_row(1'b0, 1'b0, STS_EMIT));
    rows.push_back(push_row(16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1));
    // A skipped kick still eats the point.
    rows.push_back(kick_row(1'b1, 1'b1, STS_SKIP));
    rows.push_back(reg_row(REG_PRIM_TYPE, 16'(PRIM_TRI_LIST)));
    rows.push_back(push_row(16'h0010, 16'h0020, 32'h1111_0001, 64'h0123_4567_89AB_CDEF, 1'b0));
    rows.push_back(push_row(16'h8000, 16'h0030, 32'h2222_0002, 64'hFEDC_BA98_7654_3210, 1'b0));
    rows.push_back(push_row(16'h0040, 16'h8000, 32'h3333_0003, 64'h5555_AAAA_5555_AAAA, 1'b0));
    rows.push_back(kick_row(1'b0, 1'b0, STS_EMIT));
    rows.push_back(kick_row(1'b0, 1'b1, STS_UNDER));
    // Fan: five pushes into four entries, the last one is dropped.
    rows.push_back(reg_row(REG_PRIM_TYPE, 16'(PRIM_FAN)));
    rows.push_back(push_row(16'h0100, 16'h0200, 32'hA000_0001, 64'h1, 1'b0));
    rows.push_back(push_row(16'h0300, 16'h0400, 32'hA000_0002, 64'h2, 1'b0));
    rows.push_back(push_row(16'h0500, 16'h0600, 32'hA000_0003, 64'h3, 1'b0));
    rows.push_back(push_row(16'h0700, 16'h0800, 32'hA000_0004, 64'h4, 1'b0));
    rows.push_back(push_row(16'h0900, 16'h0A00, 32'hA000_0005, 64'h5, 1'b0));
    rows.push_back(kick_row(1'b0, 1'b0, STS_EMIT));
    rows.push_back(kick_row(1'b0, 1'b0, STS_EMIT));
    // The invalid type clears the two vertices left over.
    rows.push_back(reg_row(REG_PRIM_TYPE, 16'(PRIM_INVALID)));
    rows.push_back(kick_row(1'b0, 1'b1, STS_INVALID));
    // Sprite with both corners left of the left edge is rejected; then one
    // corner exactly on the edge keeps the next sprite.
    rows.push_back(reg_row(REG_PRIM_TYPE, 16'(PRIM_SPRITE)));
    rows.push_back(reg_row(REG_X_MIN, 16'h1000));
    rows.push_back(push_row(16'h0FFF, 16'h0005, 32'hB000_0001, 64'hB1, 1'b0));
    rows.push_back(push_row(16'h0000, 16'hFFFF, 32'hB000_0002, 64'hB2, 1'b0));
    rows.push_back(kick_row(1'b0, 1'b1, STS_REJECT));
    rows.push_back(push_row(16'h1000, 16'h0000, 32'hB000_0003, 64'hB3, 1'b0));
    rows.push_back(push_row(16'h0FFF, 16'h0000, 32'hB000_0004, 64'hB4, 1'b0));
    rows.push_back(kick_row(1'b0, 1'b0, STS_EMIT));

    foreach (rows[n]) begin
      if (rows[n].kind == ROW_REG) begin
        drain();
        write_register(rows[n].reg_index, rows[n].reg_value);
      end else begin
        send_item(rows[n].item, rows[n].typed, rows[n].want);
      end
    end

    // Random part, one register setting per phase. The first eight phases
    // walk through every primitive type and the first six through the
    // scissor shapes: full screen, wide window, narrow window, a window
    // pinched to one corner, an inverted window and random edges.
    sent  = 0;
    phase = 0;
    while (sent < RandItems) begin
      drain();
      steady = 1'b0;
      if (phase < 8) new_type = pasc_prim_t'(phase);
      else new_type = pasc_prim_t'($urandom_range(0, 7));
      scissor_mode = (phase < 6) ? phase : $urandom_range(0, 5);
      case (scissor_mode)
        0: begin
          new_x_min = 16'h0000;
          new_y_min = 16'h0000;
          new_x_max = 16'hFFFF;
          new_y_max = 16'hFFFF;
        end
        1: begin
          new_x_min = 16'($urandom_range(0, 16'h7FFF));
          new_y_min = 16'($urandom_range(0, 16'h7FFF));
          new_x_max = 16'($urandom_range(16'h8000, 16'hFFFF));
          new_y_max = 16'($urandom_range(16'h8000, 16'hFFFF));
        end
        2: begin
          new_x_min = 16'($urandom_range(16'h5000, 16'h7000));
          new_y_min = 16'($urandom_range(16'h5000, 16'h7000));
          new_x_max = new_x_min + 16'h3000;
          new_y_max = new_y_min + 16'h3000;
        end
        3: begin
          // Every edge at one end of the range: only that corner survives.
          new_x_min = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
          new_y_min = new_x_min;
          new_x_max = new_x_min;
          new_y_max = new_x_min;
        end
        4: begin
          new_x_min = 16'($urandom_range(16'h8000, 16'hFFFF));
          new_y_min = 16'($urandom_range(16'h8000, 16'hFFFF));
          new_x_max = 16'($urandom_range(0, 16'h7FFF));
          new_y_max = 16'($urandom_range(0, 16'h7FFF));
        end
        default: begin
          new_x_min = 16'($urandom);
          new_y_min = 16'($urandom);
          new_x_max = 16'($urandom);
          new_y_max = 16'($urandom);
        end
      endcase
      write_register(REG_PRIM_TYPE, 16'(new_type));
      write_register(REG_X_MIN, new_x_min);
      write_register(REG_Y_MIN, new_y_min);
      write_register(REG_X_MAX, new_x_max);
      write_register(REG_Y_MAX, new_y_max);

      // Phase three runs triangle lists into a receiver that holds off for
      // a long while, so the result registers fill and the input stalls on
      // the first kick. Phase five runs with no idling on either side.
      if (phase == 3) hold_off = HoldCycles;
      steady = (phase == 5);

      need = vertices_per_primitive(new_type);
      if (need == 0) need = 1;
      phase_items = 0;
      while (phase_items < PhaseItems) begin
        if ($urandom_range(0, 99) < 80) begin
          // Well-formed: top the queue up to what the type needs, then kick.
          // The fill seen here may trail by one item, which only shifts the
          // mix a little.
          burst = (vq_fill >= need) ? 1 : need - vq_fill;
          repeat (burst) send_item(random_vertex(), 1'b0, STS_EMIT);
          it = random_vertex();
          it.opcode = OP_KICK;
          it.skip_draw = ($urandom_range(0, 7) == 0);
          send_item(it, 1'b0, STS_EMIT);
          phase_items += burst + 1;
        end else begin
          // Noise: a lone push or kick with random content.
          it = random_vertex();
          if ($urandom_range(0, 1)) it.opcode = OP_KICK;
          send_item(it, 1'b0, STS_EMIT);
          phase_items++;
        end
      end
      sent += phase_items;
      phase++;
    end

    drain();
    if (fails == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Far beyond the slowest correct run.
  initial begin : watchdog
    #4ms;
    $display("status: fail");
    $finish;
  end

endmodule
